[sv/roa_pkg.sv]
package roa_pkg;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned RangeW = 16;
  localparam int unsigned TicksW = 8;
  localparam int unsigned SpeedW = 15;
  localparam int unsigned AngW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Scan length; samples at or beyond it are ignored by the accumulators.
  localparam int unsigned MaxSamples = 1024;

  localparam logic [RangeW-1:0] StartRangeMm = RangeW'(10000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DISTANCE      = 3'd0,
    CFG_WINDOW_FIRST      = 3'd1,
    CFG_WINDOW_LAST       = 3'd2,
    CFG_RIGHT_SECTOR_END  = 3'd3,
    CFG_LEFT_SECTOR_START = 3'd4,
    CFG_TURN_TICKS        = 3'd5,
    CFG_DRIVE_SPEED       = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [RangeW-1:0] min_distance;
    logic [IdxW-1:0]   window_first;
    logic [IdxW-1:0]   window_last;
    logic [IdxW-1:0]   right_sector_end;
    logic [IdxW-1:0]   left_sector_start;
  } scan_cfg_t;

  typedef struct packed {
    logic              front_blocked;
    logic [RangeW-1:0] right_min;
    logic [RangeW-1:0] left_min;
  } scan_result_t;

endpackage

[sv/roa_if.sv]
interface roa_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [roa_pkg::IdxW-1:0]         sample_index;
  logic [roa_pkg::RangeW-1:0]       range_mm;
  logic                             last_sample;

  modport source (output valid, cmd, sample_index, range_mm, last_sample, input ready);
  modport sink   (input valid, cmd, sample_index, range_mm, last_sample, output ready);
endinterface

interface roa_out_if;
  logic                             valid;
  logic                             ready;
  logic [roa_pkg::SpeedW-1:0]       linear_speed;
  logic signed [roa_pkg::AngW-1:0]  angular_speed;

  modport source (output valid, linear_speed, angular_speed, input ready);
  modport sink   (input valid, linear_speed, angular_speed, output ready);
endinterface

[sv/roa_scan.sv]
module roa_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         sample_en_i,
  input  logic [roa_pkg::IdxW-1:0]     sample_index_i,
  input  logic [roa_pkg::RangeW-1:0]   range_mm_i,
  input  logic                         last_sample_i,
  input  roa_pkg::scan_cfg_t           cfg_i,
  output roa_pkg::scan_result_t        result_o
);
  import roa_pkg::*;

  logic              blocked_acc_q, blocked_acc_d;
  logic [RangeW-1:0] right_acc_q, right_acc_d;
  logic [RangeW-1:0] left_acc_q, left_acc_d;
  scan_result_t      result_q, result_d;

  logic in_scan, in_window, in_right, in_left;

  always_comb begin
    in_scan   = {1'b0, sample_index_i} < (IdxW + 1)'(MaxSamples);
    in_window = (sample_index_i >= cfg_i.window_first) &&
                (sample_index_i <= cfg_i.window_last);
    in_right  = sample_index_i <= cfg_i.right_sector_end;
    in_left   = sample_index_i >= cfg_i.left_sector_start;

    blocked_acc_d = blocked_acc_q;
    right_acc_d   = right_acc_q;
    left_acc_d    = left_acc_q;
    result_d      = result_q;

    if (sample_en_i) begin
      if (in_scan) begin
        if (in_window && (range_mm_i < cfg_i.min_distance)) begin
          blocked_acc_d = 1'b1;
        end
        if (in_right && (range_mm_i < right_acc_q)) begin
          right_acc_d = range_mm_i;
        end
        if (in_left && (range_mm_i < left_acc_q)) begin
          left_acc_d = range_mm_i;
        end
      end
      // The last sample is folded in before the scan is committed.
      if (last_sample_i) begin
        result_d.front_blocked = blocked_acc_d;
        result_d.right_min     = right_acc_d;
        result_d.left_min      = left_acc_d;
        blocked_acc_d = 1'b0;
        right_acc_d   = StartRangeMm;
        left_acc_d    = StartRangeMm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocked_acc_q          <= 1'b0;
      right_acc_q            <= StartRangeMm;
      left_acc_q             <= StartRangeMm;
      result_q.front_blocked <= 1'b0;
      result_q.right_min     <= StartRangeMm;
      result_q.left_min      <= StartRangeMm;
    end else begin
      blocked_acc_q <= blocked_acc_d;
      right_acc_q   <= right_acc_d;
      left_acc_q    <= left_acc_d;
      result_q      <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

[sv/reactive_obstacle_avoider_core.sv]
// Channel   Dir  Payload                                        Results
// in_if     in   cmd, sample_index, range_mm, last_sample       0 or 1 per item
// out_if    out  linear_speed, angular_speed                    only on ticks
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                none
//
// One item is accepted per cycle while in_if.ready is high; a tick's result is
// in the output register in the cycle after acceptance. The output register is the only stall point:
// in_if.ready is low only while a result is held and out_if.ready is low.
// Scan and steering state updates complete in the acceptance cycle.
// Reset is asynchronous, active low, and restores all registers and state except the output data registers.
module reactive_obstacle_avoider_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [roa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [roa_pkg::CfgDataW-1:0]  cfg_data_i,
  roa_in_if.sink                        in_if,
  roa_out_if.source                     out_if
);
  import roa_pkg::*;

  // Configuration registers.
  scan_cfg_t         scan_cfg_q;
  logic [TicksW-1:0] turn_ticks_q;
  logic [SpeedW-1:0] drive_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cfg_q.min_distance      <= RangeW'(500);
      scan_cfg_q.window_first      <= '0;
      scan_cfg_q.window_last       <= '0;
      scan_cfg_q.right_sector_end  <= '0;
      scan_cfg_q.left_sector_start <= '0;
      turn_ticks_q                 <= TicksW'(10);
      drive_speed_q                <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DISTANCE:      scan_cfg_q.min_distance      <= cfg_data_i[RangeW-1:0];
        CFG_WINDOW_FIRST:      scan_cfg_q.window_first      <= cfg_data_i[IdxW-1:0];
        CFG_WINDOW_LAST:       scan_cfg_q.window_last       <= cfg_data_i[IdxW-1:0];
        CFG_RIGHT_SECTOR_END:  scan_cfg_q.right_sector_end  <= cfg_data_i[IdxW-1:0];
        CFG_LEFT_SECTOR_START: scan_cfg_q.left_sector_start <= cfg_data_i[IdxW-1:0];
        CFG_TURN_TICKS:        turn_ticks_q                 <= cfg_data_i[TicksW-1:0];
        CFG_DRIVE_SPEED:       drive_speed_q                <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake.
  logic out_valid_q, out_valid_d;
  logic in_acc, sample_acc, tick_acc;

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;
  assign sample_acc  = in_acc && (cmd_e'(in_if.cmd) == CMD_SAMPLE);
  assign tick_acc    = in_acc && (cmd_e'(in_if.cmd) == CMD_TICK);

  scan_result_t scan;

  roa_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_en_i    (sample_acc),
    .sample_index_i (in_if.sample_index),
    .range_mm_i     (in_if.range_mm),
    .last_sample_i  (in_if.last_sample),
    .cfg_i          (scan_cfg_q),
    .result_o       (scan)
  );

  // Steering state.
  logic              may_choose_q, may_choose_d;
  logic              turn_right_q, turn_right_d;
  logic [TicksW-1:0] ticks_left_q, ticks_left_d;

  logic              res_valid;
  logic [SpeedW-1:0] res_linear;
  logic [AngW-1:0]   res_angular;
  logic [AngW-1:0]   speed_ext;

  always_comb begin
    may_choose_d = may_choose_q;
    turn_right_d = turn_right_q;
    ticks_left_d = ticks_left_q;
    res_valid    = 1'b0;
    res_linear   = '0;
    res_angular  = '0;
    speed_ext    = {1'b0, drive_speed_q};

    if (tick_acc) begin
      if (ticks_left_q != '0) begin
        ticks_left_d = ticks_left_q - TicksW'(1);
      end else if (!scan.front_blocked) begin
        may_choose_d = 1'b1;
        res_valid    = 1'b1;
        res_linear   = drive_speed_q;
      end else begin
        // The side is chosen once per blockage, then repeated.
        if (may_choose_q) begin
          may_choose_d = 1'b0;
          turn_right_d = !(scan.left_min > scan.right_min);
          ticks_left_d = turn_ticks_q;
        end
        res_valid   = 1'b1;
        res_angular = turn_right_d ? (AngW'(0) - speed_ext) : speed_ext;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      may_choose_q <= 1'b1;
      turn_right_q <= 1'b0;
      ticks_left_q <= '0;
    end else begin
      may_choose_q <= may_choose_d;
      turn_right_q <= turn_right_d;
      ticks_left_q <= ticks_left_d;
    end
  end

  // Output register.
  logic [SpeedW-1:0] out_linear_q;
  logic [AngW-1:0]   out_angular_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_linear_q  <= res_linear;
      out_angular_q <= res_angular;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.linear_speed  = out_linear_q;
  assign out_if.angular_speed = out_angular_q;

  // A held result is never overwritten or dropped while stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> (out_valid_q && $stable(out_linear_q)))
    else $error("stalled result lost or changed");

  // A tick while the turn timer runs produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_acc && (ticks_left_q != '0)) |-> !res_valid)
    else $error("result emitted during turn timer");

  // Forward and turn commands are exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_linear_q != '0)) |-> (out_angular_q == '0))
    else $error("forward command carries a turn rate");

  // The timer is only loaded when a turn side is chosen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ticks_left_q != '0 && $past(ticks_left_q) == '0) |-> $fell(may_choose_q))
    else $error("turn timer loaded without a turn decision");

endmodule
